// ===== rtl/legendre_polynomial_eval_assert.svh =====
// ----------------------------------------------------------------------------
// legendre polynomial evaluator assertion macros
// concurrent assertion forms shared by the checker
// ----------------------------------------------------------------------------
`ifndef LEGENDRE_POLYNOMIAL_EVAL_ASSERT_SVH
`define LEGENDRE_POLYNOMIAL_EVAL_ASSERT_SVH

// overlapping implication
`define LPE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// implication on the following edge
`define LPE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lpe_pkg.sv =====
// ----------------------------------------------------------------------------
// lpe_pkg
// types and fixed constants of the legendre polynomial evaluator
// ----------------------------------------------------------------------------
`default_nettype none

package lpe_pkg;

    localparam int X_W       = 32;
    localparam int ORD_W     = 9;
    localparam int ORD_TOP   = 2 ** (ORD_W - 1) - 1;
    localparam int FRAC_BITS = 30;

    localparam logic signed [X_W-1:0] FX_ONE  = X_W'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [X_W-1:0] FX_MONE = -FX_ONE;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_MT   = 9'b000000010,
        S_TR   = 9'b000000100,
        S_DN   = 9'b000001000,
        S_MQ   = 9'b000010000,
        S_MC   = 9'b000100000,
        S_CR   = 9'b001000000,
        S_UP   = 9'b010000000,
        S_DONE = 9'b100000000
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/legendre_polynomial_eval.sv =====
// ----------------------------------------------------------------------------
// legendre_polynomial_eval
// P_m(x) in signed fixed point by the three-term recurrence on one shared
// multiplier, with a reciprocal table for the division by k
// ----------------------------------------------------------------------------
//  channel | words        | handshake
//  --------+--------------+---------------------------
//  input   | x, order     | i_in_valid / o_in_stall
//  output  | poly value   | o_out_valid / i_out_stall
//
//  order <= 1: the sequencer goes from accept straight to S_DONE
//  order m >= 2: m-1 recurrence steps; each step makes three passes through the
//    one 32x32 multiplier (x*P, quotient by reciprocal, remainder check)
//  one word is in work at a time; the output register frees the input side
//  synchronous active-low reset clears the sequencer and output valid
// ----------------------------------------------------------------------------
`default_nettype none

module legendre_polynomial_eval #(
    parameter int MAX_ORDER = 255
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [lpe_pkg::X_W-1:0]      i_x_value,
    input  logic signed [lpe_pkg::ORD_W-1:0]    i_order,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [lpe_pkg::X_W-1:0]      o_poly_value
);
    import lpe_pkg::*;

    localparam int EFF_ORDER = (MAX_ORDER < ORD_TOP) ? MAX_ORDER : ORD_TOP;
    localparam int KW        = $clog2(EFF_ORDER + 1);
    localparam int PW        = 2 * X_W;
    localparam int SW        = X_W + 2;
    localparam int PKW       = X_W + 3;
    localparam int OEW       = ORD_W + 1;

    localparam logic [PW-1:0] RC_NUM   = PW'(1) << X_W;
    localparam logic [PW-1:0] RND_HALF = PW'(1) << (FRAC_BITS - 1);

    // reciprocal table, floor(2^32 / k)
    logic [X_W-1:0] w_recip [2**KW];

    for (genvar g = 0; g < 2**KW; g++) begin : g_recip
        localparam logic [X_W-1:0] RC = X_W'(RC_NUM / ((g < 2) ? 2 : g));
        assign w_recip[g] = RC;
    end

    t_state                 r_state, n_state;
    logic                   r_out_valid;
    logic signed [X_W-1:0]  r_out;
    logic signed [X_W-1:0]  r_x;
    logic [KW-1:0]          r_m;
    logic [KW-1:0]          r_k;
    logic signed [X_W-1:0]  r_pm1;
    logic signed [X_W-1:0]  r_pm2;
    logic [PW-1:0]          r_prod;
    logic                   r_tneg;
    logic signed [X_W-1:0]  r_t;
    logic [X_W-1:0]         r_n;
    logic                   r_dneg;
    logic signed [SW-1:0]   r_s;
    logic [X_W-1:0]         r_q0;
    logic [X_W-1:0]         r_q;

    logic                   w_acc;
    logic                   w_out_free;
    logic signed [X_W-1:0]  w_x_cl;
    logic signed [OEW-1:0]  w_ord_ext;
    logic [KW-1:0]          w_ord_cl;
    logic [X_W-1:0]         w_xabs;
    logic [X_W-1:0]         w_pabs;
    logic [X_W-1:0]         w_ma;
    logic [X_W-1:0]         w_mb;
    logic [PW-1:0]          w_prod;
    logic [PW-1:0]          w_rnd;
    logic [X_W-1:0]         w_tmag;
    logic signed [X_W:0]    w_d;
    logic signed [X_W:0]    w_dabs;
    logic signed [SW-1:0]   w_s;
    logic [X_W-1:0]         w_rem;
    logic signed [PKW-1:0]  w_qext;
    logic signed [PKW-1:0]  w_pk;
    logic signed [X_W-1:0]  w_pk_sat;

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_poly_value = r_out;
    assign w_acc        = i_in_valid && !o_in_stall;
    assign w_out_free   = !r_out_valid || !i_out_stall;

    // argument and order clamps
    always_comb begin
        if (i_x_value > FX_ONE) begin
            w_x_cl = FX_ONE;
        end else if (i_x_value < FX_MONE) begin
            w_x_cl = FX_MONE;
        end else begin
            w_x_cl = i_x_value;
        end
        w_ord_ext = {i_order[ORD_W-1], i_order};
        if (w_ord_ext > $signed(OEW'(EFF_ORDER))) begin
            w_ord_cl = KW'(EFF_ORDER);
        end else begin
            w_ord_cl = w_ord_ext[KW-1:0];
        end
    end

    // shared multiplier operand select
    assign w_xabs = r_x[X_W-1] ? X_W'(-r_x) : X_W'(r_x);
    assign w_pabs = r_pm1[X_W-1] ? X_W'(-r_pm1) : X_W'(r_pm1);

    always_comb begin
        case (r_state)
            S_MQ: begin
                w_ma = r_n;
                w_mb = w_recip[r_k];
            end
            S_MC: begin
                w_ma = r_prod[PW-1:X_W];
                w_mb = X_W'(r_k);
            end
            default: begin
                w_ma = w_xabs;
                w_mb = w_pabs;
            end
        endcase
    end

    assign w_prod = PW'(w_ma) * PW'(w_mb);

    // step arithmetic
    assign w_rnd  = r_prod + RND_HALF;
    assign w_tmag = w_rnd[FRAC_BITS+X_W-1:FRAC_BITS];
    assign w_d    = (X_W+1)'(r_t) - (X_W+1)'(r_pm2);
    assign w_dabs = w_d[X_W] ? -w_d : w_d;
    assign w_s    = (SW'(r_t) <<< 1) - SW'(r_pm2);
    assign w_rem  = r_n - r_prod[X_W-1:0];
    assign w_qext = $signed(PKW'({1'b0, r_q}));
    assign w_pk   = r_dneg ? (PKW'(r_s) + w_qext) : (PKW'(r_s) - w_qext);

    always_comb begin
        if (w_pk > PKW'(FX_ONE)) begin
            w_pk_sat = FX_ONE;
        end else if (w_pk < PKW'(FX_MONE)) begin
            w_pk_sat = FX_MONE;
        end else begin
            w_pk_sat = w_pk[X_W-1:0];
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_state = (w_ord_ext <= $signed(OEW'(1))) ? S_DONE : S_MT;
                end
            end
            S_MT:   n_state = S_TR;
            S_TR:   n_state = S_DN;
            S_DN:   n_state = S_MQ;
            S_MQ:   n_state = S_MC;
            S_MC:   n_state = S_CR;
            S_CR:   n_state = S_UP;
            S_UP:   n_state = (r_k == r_m) ? S_DONE : S_MT;
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    r_x   <= w_x_cl;
                    r_m   <= w_ord_cl;
                    r_k   <= KW'(2);
                    r_pm2 <= FX_ONE;
                    r_pm1 <= (w_ord_ext <= $signed(OEW'(0))) ? FX_ONE : w_x_cl;
                end
            end
            S_MT: begin
                r_prod <= w_prod;
                r_tneg <= r_x[X_W-1] ^ r_pm1[X_W-1];
            end
            S_TR: begin
                r_t <= r_tneg ? -$signed(w_tmag) : $signed(w_tmag);
            end
            S_DN: begin
                r_n    <= w_dabs[X_W-1:0] + X_W'(r_k >> 1);
                r_dneg <= w_d[X_W];
            end
            S_MQ: begin
                r_prod <= w_prod;
                r_s    <= w_s;
            end
            S_MC: begin
                r_prod <= w_prod;
                r_q0   <= r_prod[PW-1:X_W];
            end
            S_CR: begin
                r_q <= r_q0 + X_W'(w_rem >= X_W'(r_k));
            end
            S_UP: begin
                r_pm2 <= r_pm1;
                r_pm1 <= w_pk_sat;
                r_k   <= r_k + KW'(1);
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_out <= r_pm1;
                end
            end
            default: begin
                r_k <= r_k;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/lpe_checker.sv =====
// ----------------------------------------------------------------------------
// lpe_checker
// port-level checks of the legendre polynomial evaluator
// ----------------------------------------------------------------------------
`default_nettype none

`include "legendre_polynomial_eval_assert.svh"

module lpe_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                o_in_stall,
    input  logic signed [lpe_pkg::ORD_W-1:0]    i_order,
    input  logic                                o_out_valid,
    input  logic                                i_out_stall,
    input  logic signed [lpe_pkg::X_W-1:0]      o_poly_value
);
    import lpe_pkg::*;

    logic w_in_acc;
    logic w_bad_ord;

    assign w_in_acc  = i_in_valid && !o_in_stall;
    assign w_bad_ord = i_order[ORD_W-1] || (i_order == ORD_W'(0));

    // stalled result word holds
    `LPE_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_poly_value), "stalled result word changed")

    // result stays within plus or minus one
    `LPE_ASSERT_IMP(a_out_range, i_clk, i_rst_n, o_out_valid, (o_poly_value <= FX_ONE) && (o_poly_value >= FX_MONE), "result outside unit range")

    // busy after taking a word
    `LPE_ASSERT_NXT(a_busy, i_clk, i_rst_n, w_in_acc, o_in_stall, "input not stalled after accept")

    // order zero or negative gives one
    `LPE_ASSERT_IMP(a_bad_ord, i_clk, i_rst_n, w_in_acc && !o_out_valid && w_bad_ord, ##2 (o_out_valid && (o_poly_value == FX_ONE)), "low order did not give one")

endmodule

bind legendre_polynomial_eval lpe_checker u_lpe_checker (.*);

`default_nettype wire

// ===== tb/sv/legendre_polynomial_eval_test.sv =====
// ----------------------------------------------------------------------------
// legendre_polynomial_eval_test
// Self-checking bench for the Legendre polynomial evaluator. A queue of words
// (directed corner cases, then random words with mostly small orders) feeds
// a clocked driver. A clocked monitor predicts P_m(x) for each accepted word
// with its own fixed-point recurrence and checks the results in order. Both
// sides idle and stall in random bursts, and a watchdog ends a hung run.
// ----------------------------------------------------------------------------
`default_nettype none

module legendre_polynomial_eval_test;

    localparam int ORDER_CAP = 255;
    localparam int FB = lpe_pkg::FRAC_BITS;
    localparam int ORD_W = lpe_pkg::ORD_W;
    localparam longint UNIT = 64'sd1 <<< FB;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_WORDS = 80;
    localparam int RANDOM_WORDS = 760;

    typedef struct {
        logic signed [lpe_pkg::X_W-1:0]   x;
        logic signed [lpe_pkg::ORD_W-1:0] ord;
        bit                               drain;
    } poly_job_t;

    logic                              i_clk;
    logic                              i_rst_n = 1'b0;
    logic                              i_in_valid = 1'b0;
    logic                              o_in_stall;
    logic signed [lpe_pkg::X_W-1:0]    i_x_value = '0;
    logic signed [lpe_pkg::ORD_W-1:0]  i_order = '0;
    logic                              o_out_valid;
    logic                              i_out_stall = 1'b0;
    logic signed [lpe_pkg::X_W-1:0]    o_poly_value;

    poly_job_t                         job_queue[$];
    logic signed [lpe_pkg::X_W-1:0]    poly_due[$];
    logic signed [lpe_pkg::X_W-1:0]    due_value;
    int                                sent_count = 0;
    int                                taken_count = 0;
    bit                                moved;
    int                                gap_left = 0;
    int                                stall_left = 0;
    int                                idle_cycles = 0;
    int                                mismatch_count = 0;

    legendre_polynomial_eval #(
        .MAX_ORDER(ORDER_CAP)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_x_value   (i_x_value),
        .i_order     (i_order),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_poly_value(o_poly_value)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint clamp_unit(input longint v);
        if (v > UNIT) return UNIT;
        if (v < -UNIT) return -UNIT;
        return v;
    endfunction

    // P_m(x) by the three-term recurrence, rounded and saturated per step
    function automatic logic signed [lpe_pkg::X_W-1:0] legendre_value(
        input logic signed [lpe_pkg::X_W-1:0]   x_in,
        input logic signed [lpe_pkg::ORD_W-1:0] ord_in
    );
        longint x, p_two_back, p_one_back, p_now, ma, mb, t, d, q;
        int m;
        x = clamp_unit(longint'(x_in));
        m = int'(ord_in);
        if (m > ORDER_CAP) m = ORDER_CAP;
        if (m <= 0) begin
            p_now = UNIT;
        end else if (m == 1) begin
            p_now = x;
        end else begin
            p_two_back = UNIT;
            p_one_back = x;
            p_now = x;
            for (int k = 2; k <= m; k++) begin
                ma = (x < 0) ? -x : x;
                mb = (p_one_back < 0) ? -p_one_back : p_one_back;
                t = (ma * mb + (64'sd1 <<< (FB - 1))) >>> FB;
                if ((x < 0) != (p_one_back < 0)) t = -t;
                d = t - p_two_back;
                q = (((d < 0) ? -d : d) + longint'(k / 2)) / longint'(k);
                if (d < 0) q = -q;
                p_now = clamp_unit(2 * t - p_two_back - q);
                p_two_back = p_one_back;
                p_one_back = p_now;
            end
        end
        return p_now[lpe_pkg::X_W-1:0];
    endfunction

    function automatic bit quiet_tail();
        return job_queue.size() < TAIL_WORDS;
    endfunction

    task automatic report_mismatch(
        input string                           what,
        input logic signed [lpe_pkg::X_W-1:0]  got,
        input logic signed [lpe_pkg::X_W-1:0]  want
    );
        $display("%0t %s: got %h expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic add_job(
        input logic signed [lpe_pkg::X_W-1:0]   x,
        input logic signed [lpe_pkg::ORD_W-1:0] ord,
        input bit                               drain
    );
        poly_job_t job;
        job.x = x;
        job.ord = ord;
        job.drain = drain;
        job_queue.push_back(job);
    endtask

    // input driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || taken_count == sent_count) begin
            if (gap_left == 0 && job_queue.size() > 0 && !quiet_tail() &&
                $urandom_range(0, 7) == 0) begin
                gap_left = $urandom_range(1, 18);
            end
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (job_queue.size() > 0 &&
                         !(job_queue[0].drain && poly_due.size() > 0)) begin
                i_x_value  <= job_queue[0].x;
                i_order    <= job_queue[0].ord;
                i_in_valid <= 1'b1;
                sent_count++;
                void'(job_queue.pop_front());
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output back-pressure
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (!quiet_tail() && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 18) - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // monitor, checker and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            moved = 1'b0;
            if (i_in_valid && !o_in_stall) begin
                poly_due.push_back(legendre_value(i_x_value, i_order));
                taken_count++;
                moved = 1'b1;
            end
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                if (poly_due.size() == 0) begin
                    report_mismatch("poly word with nothing due", o_poly_value, '0);
                end else begin
                    due_value = poly_due.pop_front();
                    if (o_poly_value !== due_value)
                        report_mismatch("poly word", o_poly_value, due_value);
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        longint lx;
        int pick;
        int neg_ord;
        logic signed [lpe_pkg::X_W-1:0]   x;
        logic signed [lpe_pkg::ORD_W-1:0] ord;

        // corner cases: bad orders, zero and one, clamped x, saturation near
        // +/-1.0, deepest recurrence
        add_job(32'sd0,                 -9'sd1,   1'b0);
        add_job(lpe_pkg::FX_ONE,        -9'sd256, 1'b0);
        add_job(32'sh7fffffff,          9'sd0,    1'b0);
        add_job(32'sh80000000,          9'sd1,    1'b0);
        add_job(lpe_pkg::FX_ONE + 1,    9'sd1,    1'b0);
        add_job(lpe_pkg::FX_MONE - 1,   9'sd1,    1'b0);
        add_job(lpe_pkg::FX_ONE,        9'sd255,  1'b0);
        add_job(lpe_pkg::FX_MONE,       9'sd255,  1'b0);
        add_job(lpe_pkg::FX_MONE,       9'sd254,  1'b0);
        add_job(32'sd0,                 9'sd255,  1'b0);
        add_job(32'sd0,                 9'sd2,    1'b0);
        add_job(32'sh20000000,          9'sd2,    1'b0);
        add_job(-32'sh20000000,         9'sd3,    1'b0);
        add_job(lpe_pkg::FX_ONE,        9'sd20,   1'b0);
        add_job(lpe_pkg::FX_MONE,       9'sd21,   1'b0);
        add_job(lpe_pkg::FX_ONE - 1,    9'sd40,   1'b0);
        add_job(32'sh7fffffff,          9'sd255,  1'b0);
        add_job(32'sh80000000,          9'sd7,    1'b0);
        add_job(32'sd1,                 9'sd2,    1'b0);
        add_job(-32'sd1,                9'sd3,    1'b0);
        add_job(32'sh12345678,          9'sd10,   1'b0);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                lx = longint'($urandom_range(0, 32'h80000000)) - UNIT;
                x = lx[lpe_pkg::X_W-1:0];
            end else if (pick < 80) begin
                x = lpe_pkg::FX_ONE - $urandom_range(0, 4096);
                if ($urandom_range(0, 1) == 1) x = -x;
            end else begin
                x = $urandom();
            end
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                ord = ORD_W'($urandom_range(0, 12));
            end else if (pick < 85) begin
                ord = ORD_W'($urandom_range(13, 64));
            end else if (pick < 95) begin
                neg_ord = -int'($urandom_range(1, 256));
                ord = neg_ord[lpe_pkg::ORD_W-1:0];
            end else begin
                ord = ORD_W'($urandom_range(200, 255));
            end
            add_job(x, ord, (n % 150) == 0);
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (job_queue.size() > 0 || i_in_valid) @(posedge i_clk);
        while (poly_due.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire
